/* rtl/ohlc_bar_consolidator_macros.svh */
// Assertion macros shared by the OHLC bar consolidator RTL.
`ifndef OHLC_BAR_CONSOLIDATOR_MACROS_SVH
`define OHLC_BAR_CONSOLIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/obc_pkg.sv */
// Package: widths, register indexes and types of the OHLC bar consolidator.
`timescale 1ns / 1ps
package obc_pkg;

    localparam int TimeW    = 48;
    localparam int PriceW   = 32;
    localparam int InVolW   = 32;
    localparam int VolW     = 40;
    localparam int CountW   = 16;
    localparam int PeriodW  = 40;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 40;

    localparam logic [CfgIdxW-1:0] CfgIdxCountEnable  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgIdxCountLimit   = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CfgIdxPeriodEnable = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CfgIdxPeriodTicks  = CfgIdxW'(3);

    typedef struct packed {
        logic               count_en;
        logic [CountW-1:0]  count_limit;
        logic               period_en;
        logic [PeriodW-1:0] period_ticks;
    } t_cfg;

    typedef struct packed {
        logic [TimeW-1:0]  timestamp;
        logic [PriceW-1:0] open_price;
        logic [PriceW-1:0] high_price;
        logic [PriceW-1:0] low_price;
        logic [PriceW-1:0] close_price;
        logic [InVolW-1:0] trade_volume;
    } t_item;

    typedef struct packed {
        logic [TimeW-1:0]  bar_time;
        logic [PriceW-1:0] bar_open;
        logic [PriceW-1:0] bar_high;
        logic [PriceW-1:0] bar_low;
        logic [PriceW-1:0] bar_close;
        logic [VolW-1:0]   bar_volume;
    } t_bar;

    typedef struct packed {
        logic [CountW-1:0] item_count;
        logic [TimeW-1:0]  last_emit_time;
        logic              last_emit_valid;
    } t_track;

endpackage

/* rtl/obc_if.sv */
// Interfaces: input item, output bar and configuration write channels.
`timescale 1ns / 1ps
interface obc_item_if;
    logic                        valid;
    logic                        ready;
    logic [obc_pkg::TimeW-1:0]   timestamp;
    logic [obc_pkg::PriceW-1:0]  open_price;
    logic [obc_pkg::PriceW-1:0]  high_price;
    logic [obc_pkg::PriceW-1:0]  low_price;
    logic [obc_pkg::PriceW-1:0]  close_price;
    logic [obc_pkg::InVolW-1:0]  trade_volume;

    modport source (output valid, timestamp, open_price, high_price, low_price,
                    close_price, trade_volume, input ready);
    modport sink (input valid, timestamp, open_price, high_price, low_price,
                  close_price, trade_volume, output ready);
endinterface

interface obc_bar_if;
    logic                        valid;
    logic                        ready;
    logic [obc_pkg::TimeW-1:0]   bar_time;
    logic [obc_pkg::PriceW-1:0]  bar_open;
    logic [obc_pkg::PriceW-1:0]  bar_high;
    logic [obc_pkg::PriceW-1:0]  bar_low;
    logic [obc_pkg::PriceW-1:0]  bar_close;
    logic [obc_pkg::VolW-1:0]    bar_volume;

    modport source (output valid, bar_time, bar_open, bar_high, bar_low, bar_close,
                    bar_volume, input ready);
    modport sink (input valid, bar_time, bar_open, bar_high, bar_low, bar_close,
                  bar_volume, output ready);
endinterface

interface obc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [obc_pkg::CfgIdxW-1:0]  index;
    logic [obc_pkg::CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/obc_fold.sv */
// Fold datapath: merges one item into the working bar, or starts a bar from it, and evaluates both triggers.
`timescale 1ns / 1ps
module obc_fold (
    input  obc_pkg::t_item  i_item,
    input  obc_pkg::t_bar   i_bar,
    input  logic            i_present,
    input  obc_pkg::t_track i_track,
    input  obc_pkg::t_cfg   i_cfg,
    output obc_pkg::t_bar   o_bar,
    output obc_pkg::t_track o_track,
    output logic            o_fire
);

    logic [obc_pkg::VolW:0]        s_vol_sum;
    logic [obc_pkg::VolW-1:0]      s_vol_sat;
    logic [obc_pkg::CountW-1:0]    s_count_inc;
    logic                          s_count_fire;
    logic [obc_pkg::TimeW-1:0]     s_base;
    logic [obc_pkg::TimeW-1:0]     s_diff;
    logic                          s_period_fire;

    assign s_vol_sum = {1'b0, i_bar.bar_volume} + (obc_pkg::VolW + 1)'(i_item.trade_volume);
    assign s_vol_sat = s_vol_sum[obc_pkg::VolW] ? {obc_pkg::VolW{1'b1}}
                                                : s_vol_sum[obc_pkg::VolW-1:0];

    always_comb begin
        if (!i_present) begin
            o_bar.bar_time   = i_item.timestamp;
            o_bar.bar_open   = i_item.open_price;
            o_bar.bar_high   = i_item.high_price;
            o_bar.bar_low    = i_item.low_price;
            o_bar.bar_close  = i_item.close_price;
            o_bar.bar_volume = obc_pkg::VolW'(i_item.trade_volume);
        end else begin
            o_bar.bar_time   = i_bar.bar_time;
            o_bar.bar_open   = i_bar.bar_open;
            o_bar.bar_high   = (i_item.high_price > i_bar.bar_high) ? i_item.high_price
                                                                    : i_bar.bar_high;
            o_bar.bar_low    = (i_item.low_price < i_bar.bar_low) ? i_item.low_price
                                                                  : i_bar.bar_low;
            o_bar.bar_close  = i_item.close_price;
            o_bar.bar_volume = s_vol_sat;
        end
    end

    // Count trigger: saturating increment, fire at the limit.
    assign s_count_inc  = (&i_track.item_count) ? i_track.item_count
                                                : i_track.item_count + 1'b1;
    assign s_count_fire = i_cfg.count_en && (s_count_inc >= i_cfg.count_limit);

    // Period trigger: the first item seeds the reference time.
    assign s_base        = i_track.last_emit_valid ? i_track.last_emit_time : i_item.timestamp;
    assign s_diff        = i_item.timestamp - s_base;
    assign s_period_fire = i_cfg.period_en && (i_item.timestamp >= s_base)
                           && (s_diff >= obc_pkg::TimeW'(i_cfg.period_ticks));

    assign o_fire = s_count_fire || s_period_fire;

    always_comb begin
        o_track = i_track;
        if (i_cfg.count_en) begin
            o_track.item_count = s_count_fire ? '0 : s_count_inc;
        end
        if (i_cfg.period_en) begin
            o_track.last_emit_valid = 1'b1;
            o_track.last_emit_time  = o_fire ? i_item.timestamp : s_base;
        end
    end

endmodule

/* rtl/ohlc_bar_consolidator.sv */
// Top level of the OHLC bar consolidator: state, configuration and output buffering.
// A completed bar is registered in r_out, or in the skid entry while r_out is full and stalled.
// Throughput: one item per cycle while the skid entry is empty; items that fire nothing produce no result.
// A two-deep output stage (result register plus skid) lets items keep flowing while
// a bar waits; input ready drops only when both entries hold an undelivered bar.
// Reset (synchronous, active low) zeroes the config registers, drops the working bar,
// clears the item count and emit reference, and empties the output stage.
`timescale 1ns / 1ps
`include "ohlc_bar_consolidator_macros.svh"
module ohlc_bar_consolidator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    obc_cfg_if.sink      i_cfg,
    obc_item_if.sink     i_item,
    obc_bar_if.source    o_bar
);

    // Configuration registers
    obc_pkg::t_cfg   r_cfg;

    // Working bar and trigger tracking
    logic            r_present, n_present;
    obc_pkg::t_bar   r_bar, n_bar;
    obc_pkg::t_track r_track, n_track;

    // Output stage: result register and skid entry
    logic            r_out_valid, n_out_valid;
    obc_pkg::t_bar   r_out, n_out;
    logic            r_skid_valid, n_skid_valid;
    obc_pkg::t_bar   r_skid, n_skid;

    obc_pkg::t_item  s_item;
    obc_pkg::t_bar   s_bar_next;
    obc_pkg::t_track s_track_next;
    logic            s_fire;
    logic            s_accept;
    logic            s_push;
    logic            s_pop;

    // Configuration writes are always taken; unknown indexes drop silently.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                obc_pkg::CfgIdxCountEnable:  r_cfg.count_en     <= i_cfg.data[0];
                obc_pkg::CfgIdxCountLimit:   r_cfg.count_limit  <= i_cfg.data[obc_pkg::CountW-1:0];
                obc_pkg::CfgIdxPeriodEnable: r_cfg.period_en    <= i_cfg.data[0];
                obc_pkg::CfgIdxPeriodTicks:  r_cfg.period_ticks <= i_cfg.data[obc_pkg::PeriodW-1:0];
                default: ;
            endcase
        end
    end

    assign s_item = '{timestamp:    i_item.timestamp,
                      open_price:   i_item.open_price,
                      high_price:   i_item.high_price,
                      low_price:    i_item.low_price,
                      close_price:  i_item.close_price,
                      trade_volume: i_item.trade_volume};

    obc_fold u_fold (
        .i_item    (s_item),
        .i_bar     (r_bar),
        .i_present (r_present),
        .i_track   (r_track),
        .i_cfg     (r_cfg),
        .o_bar     (s_bar_next),
        .o_track   (s_track_next),
        .o_fire    (s_fire)
    );

    // Hold input only while the skid entry is occupied.
    assign i_item.ready = !r_skid_valid;
    assign s_accept     = i_item.valid && !r_skid_valid;
    assign s_push       = s_accept && s_fire;
    assign s_pop        = r_out_valid && o_bar.ready;

    always_comb begin
        n_present    = r_present;
        n_bar        = r_bar;
        n_track      = r_track;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;

        // Advance the working bar; a firing item leaves it empty.
        if (s_accept) begin
            n_present = !s_fire;
            n_bar     = s_bar_next;
            n_track   = s_track_next;
        end

        priority if (r_skid_valid) begin
            // Input is held here, so only a drain can happen.
            if (s_pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (s_push) begin
            if (!r_out_valid || s_pop) begin
                n_out       = s_bar_next;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = s_bar_next;
                n_skid_valid = 1'b1;
            end
        end else if (s_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present    <= 1'b0;
            r_track      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_present    <= n_present;
            r_track      <= n_track;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Bar payload needs no reset: it is read only once a bar is present or queued.
    always_ff @(posedge i_clk) begin
        r_bar  <= n_bar;
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_bar.valid      = r_out_valid;
    assign o_bar.bar_time   = r_out.bar_time;
    assign o_bar.bar_open   = r_out.bar_open;
    assign o_bar.bar_high   = r_out.bar_high;
    assign o_bar.bar_low    = r_out.bar_low;
    assign o_bar.bar_close  = r_out.bar_close;
    assign o_bar.bar_volume = r_out.bar_volume;

    `OBC_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `OBC_ASSERT_NEXT(a_push_to_empty, i_clk, i_rst_n, s_push && !r_out_valid, r_out_valid && !r_skid_valid)
    `OBC_ASSERT_NOW(a_zero_limit_fires, i_clk, i_rst_n, s_accept && r_cfg.count_en && (r_cfg.count_limit == '0), s_fire)
    `OBC_ASSERT_NEXT(a_fire_clears_bar, i_clk, i_rst_n, s_accept && s_fire, !r_present)
    `OBC_ASSERT_NEXT(a_fold_keeps_bar, i_clk, i_rst_n, s_accept && !s_fire, r_present)

endmodule

/* tb/sv/ohlc_bar_consolidator_tb.sv */
// Testbench of the OHLC bar consolidator: directed and random items checked against a built-in model.
`timescale 1ns / 1ps
module ohlc_bar_consolidator_tb;
    import obc_pkg::*;

    // Cycles with no handshake on any channel before the run is declared hung.
    localparam int unsigned IdleLimit  = 2000;
    // Cycles to let pass once the last expected bar is out.
    localparam int unsigned DrainSlack = 4;
    localparam int unsigned EndSlack   = 8;
    localparam int unsigned RandPhases = 8;
    localparam int unsigned PhaseItems = 150;
    localparam int unsigned SatItems   = 260;
    // First and last register index that the block has no register for.
    localparam logic [CfgIdxW-1:0] CfgIdxFirstUnused = CfgIdxPeriodTicks + 1'b1;
    localparam logic [CfgIdxW-1:0] CfgIdxLastUnused  = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    obc_cfg_if  cfg_ch ();
    obc_item_if item_ch ();
    obc_bar_if  bar_ch ();

    ohlc_bar_consolidator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_item  (item_ch),
        .o_bar   (bar_ch)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Model of the block: register mirror, working bar and trigger tracking
    // ---------------------------------------------------------------------
    logic               mdl_count_en    = 1'b0;
    logic [CountW-1:0]  mdl_count_limit = '0;
    logic               mdl_period_en   = 1'b0;
    logic [PeriodW-1:0] mdl_period      = '0;

    logic   bar_open  = 1'b0;
    t_bar   work_bar  = '0;
    t_track track     = '0;

    // Completed bars still to come out of the block, oldest first.
    t_bar   expected_bars[$];

    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;

    // Sender state: items left in the current burst and the running item time.
    int unsigned      burst_left = 0;
    logic [TimeW-1:0] ts_cursor  = '0;

    // Fold one item into the working bar; return 1 and the finished bar when a trigger fires.
    function automatic bit fold_item(input t_item it, output t_bar finished);
        logic [VolW:0]    vol_sum;
        logic [TimeW-1:0] elapsed;
        bit               fire;
        fire = 1'b0;
        if (!bar_open) begin
            bar_open            = 1'b1;
            work_bar.bar_time   = it.timestamp;
            work_bar.bar_open   = it.open_price;
            work_bar.bar_high   = it.high_price;
            work_bar.bar_low    = it.low_price;
            work_bar.bar_close  = it.close_price;
            work_bar.bar_volume = VolW'(it.trade_volume);
        end else begin
            work_bar.bar_close = it.close_price;
            if (it.low_price < work_bar.bar_low) begin
                work_bar.bar_low = it.low_price;
            end
            if (it.high_price > work_bar.bar_high) begin
                work_bar.bar_high = it.high_price;
            end
            // Saturate the volume at full scale rather than wrap.
            vol_sum = {1'b0, work_bar.bar_volume} + (VolW + 1)'(it.trade_volume);
            work_bar.bar_volume = vol_sum[VolW] ? '1 : vol_sum[VolW-1:0];
        end

        // Count trigger: the count sticks at full scale and survives register writes.
        if (mdl_count_en) begin
            if (track.item_count != '1) begin
                track.item_count = track.item_count + 1'b1;
            end
            if (track.item_count >= mdl_count_limit) begin
                track.item_count = '0;
                fire = 1'b1;
            end
        end

        // Period trigger: the first item seen while enabled sets the reference time;
        // an item older than the reference never fires.
        if (mdl_period_en) begin
            if (!track.last_emit_valid) begin
                track.last_emit_time  = it.timestamp;
                track.last_emit_valid = 1'b1;
            end
            elapsed = it.timestamp - track.last_emit_time;
            if (it.timestamp >= track.last_emit_time && elapsed >= TimeW'(mdl_period)) begin
                fire = 1'b1;
            end
        end

        finished = work_bar;
        if (fire) begin
            if (mdl_period_en) begin
                track.last_emit_time = it.timestamp;
            end
            bar_open = 1'b0;
            work_bar = '0;
        end
        return fire;
    endfunction

    task automatic check_field(input string field, input logic [TimeW-1:0] want,
                               input logic [TimeW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Monitor: check each delivered bar, mirror register writes, predict on
    // each accepted item. Results come from a register behind their item, so check first.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_item seen;
        t_bar  want;
        t_bar  finished;
        if (i_rst_n) begin
            if (bar_ch.valid && bar_ch.ready) begin
                if (expected_bars.size() == 0) begin
                    $display("%0t: unexpected bar: expected none, actual time %0h open %0h",
                             $time, bar_ch.bar_time, bar_ch.bar_open);
                    mismatches++;
                end else begin
                    want = expected_bars.pop_front();
                    check_field("bar_time",   want.bar_time,   bar_ch.bar_time);
                    check_field("bar_open",   TimeW'(want.bar_open),   TimeW'(bar_ch.bar_open));
                    check_field("bar_high",   TimeW'(want.bar_high),   TimeW'(bar_ch.bar_high));
                    check_field("bar_low",    TimeW'(want.bar_low),    TimeW'(bar_ch.bar_low));
                    check_field("bar_close",  TimeW'(want.bar_close),  TimeW'(bar_ch.bar_close));
                    check_field("bar_volume", TimeW'(want.bar_volume),
                                TimeW'(bar_ch.bar_volume));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                // Keep only the register's own bits; drop writes to unknown indexes.
                case (cfg_ch.index)
                    CfgIdxCountEnable:  mdl_count_en    = cfg_ch.data[0];
                    CfgIdxCountLimit:   mdl_count_limit = cfg_ch.data[CountW-1:0];
                    CfgIdxPeriodEnable: mdl_period_en   = cfg_ch.data[0];
                    CfgIdxPeriodTicks:  mdl_period      = cfg_ch.data[PeriodW-1:0];
                    default: ;
                endcase
            end
            if (item_ch.valid && item_ch.ready) begin
                seen.timestamp    = item_ch.timestamp;
                seen.open_price   = item_ch.open_price;
                seen.high_price   = item_ch.high_price;
                seen.low_price    = item_ch.low_price;
                seen.close_price  = item_ch.close_price;
                seen.trade_volume = item_ch.trade_volume;
                if (fold_item(seen, finished)) begin
                    expected_bars.push_back(finished);
                end
            end
        end
    end

    // Watchdog: give up when nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (bar_ch.valid && bar_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: stall on a periodic pattern that is redrawn after a random hold;
    // about a quarter of the stretches never stall.
    initial begin : bar_stall_pattern
        int unsigned stall_period;
        int unsigned stall_len;
        int unsigned phase;
        int unsigned hold;
        bar_ch.ready = 1'b1;
        stall_period = 1;
        stall_len    = 0;
        phase        = 0;
        hold         = 0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                hold         = $urandom_range(16, 96);
                stall_period = $urandom_range(2, 9);
                stall_len    = ($urandom_range(0, 3) == 0) ? 0
                                                           : $urandom_range(1, stall_period - 1);
            end
            hold--;
            phase        = (phase + 1) % stall_period;
            bar_ch.ready = (phase >= stall_len);
        end
    end

    // ---------------------------------------------------------------------
    // Drivers. All are called at a falling edge and return at one.
    // ---------------------------------------------------------------------

    // Offer one item; open a new burst, maybe after a gap, when the last one ran out.
    // Valid stays high on return so that back-to-back items need no extra write.
    task automatic send_item(input t_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                item_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        item_ch.timestamp    = it.timestamp;
        item_ch.open_price   = it.open_price;
        item_ch.high_price   = it.high_price;
        item_ch.low_price    = it.low_price;
        item_ch.close_price  = it.close_price;
        item_ch.trade_volume = it.trade_volume;
        item_ch.valid        = 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
    endtask

    // Hold the sender until every expected bar is out, then wait out the given slack.
    task automatic drain_results(input int unsigned slack);
        item_ch.valid = 1'b0;
        burst_left    = 0;
        while (expected_bars.size() != 0) @(negedge i_clk);
        repeat (slack) @(negedge i_clk);
    endtask

    // Write one register; valid stays high for a following write.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    // Drain, then write all four registers with random bits above each field narrower
    // than the data word, and now and then a write to an index with no register behind it.
    task automatic configure(input logic count_en, input logic [CountW-1:0] count_limit,
                             input logic period_en, input logic [PeriodW-1:0] period);
        logic [63:0] noise;
        drain_results(DrainSlack);
        noise = {$urandom, $urandom};
        write_reg(CfgIdxCountEnable, {noise[CfgDataW-1:1], count_en});
        write_reg(CfgIdxCountLimit, {noise[CfgDataW-1:CountW], count_limit});
        write_reg(CfgIdxPeriodEnable, {noise[CfgDataW:2], period_en});
        write_reg(CfgIdxPeriodTicks, CfgDataW'(period));
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CfgIdxW'($urandom_range(CfgIdxFirstUnused, CfgIdxLastUnused)),
                      noise[CfgDataW+7:8]);
        end
        cfg_ch.valid = 1'b0;
    endtask

    function automatic t_item quote(input logic [TimeW-1:0] ts, input logic [PriceW-1:0] op,
                                    input logic [PriceW-1:0] hp, input logic [PriceW-1:0] lp,
                                    input logic [PriceW-1:0] cp, input logic [InVolW-1:0] vol);
        t_item it;
        it.timestamp    = ts;
        it.open_price   = op;
        it.high_price   = hp;
        it.low_price    = lp;
        it.close_price  = cp;
        it.trade_volume = vol;
        return it;
    endfunction

    // Draw a market-like item: time mostly moving forward, low <= open, close <= high.
    // A few items step back in time, jump anywhere or carry random prices.
    function automatic t_item make_bar_item(input int unsigned step_max);
        t_item             it;
        logic [PriceW-1:0] lo;
        logic [PriceW-1:0] hi;
        logic [PriceW-1:0] span;
        logic [63:0]       noise;
        int unsigned       roll;
        noise = {$urandom, $urandom};
        roll  = $urandom_range(0, 31);
        if (roll == 0) begin
            ts_cursor = noise[TimeW-1:0];
        end else if (roll < 3) begin
            ts_cursor = ts_cursor - $urandom_range(0, step_max);
        end else begin
            ts_cursor = ts_cursor + $urandom_range(0, step_max);
        end
        it.timestamp = ts_cursor;

        if ($urandom_range(0, 7) == 0) begin
            it.open_price  = $urandom;
            it.high_price  = $urandom;
            it.low_price   = $urandom;
            it.close_price = $urandom;
        end else begin
            span = $urandom_range(0, 4096);
            lo   = $urandom;
            // Push some bars against the ends of the price range.
            if ($urandom_range(0, 15) == 0) begin
                lo = ($urandom_range(0, 1) == 0) ? '0 : ('1 - span);
            end
            hi = lo + span;
            if (hi < lo) begin
                hi = '1;
            end
            it.low_price   = lo;
            it.high_price  = hi;
            it.open_price  = lo + $urandom_range(0, hi - lo);
            it.close_price = lo + $urandom_range(0, hi - lo);
        end
        it.trade_volume = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5000);
        return it;
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // With the registers at reset nothing fires and the bar keeps growing;
    // then a count limit of zero releases it on the next item and every one after.
    task automatic test_accumulate_without_trigger();
        send_item(quote(48'd0, 32'd100, 32'd120, 32'd90, 32'd110, 32'd10));
        send_item(quote('1, '1, '1, '0, '1, '1));
        send_item(quote(48'd5, '0, '0, '0, '0, '0));
        configure(1'b1, '0, 1'b0, '0);
        send_item(quote(48'd7, 32'd50, 32'd60, 32'd40, 32'd55, '1));
        send_item(quote(48'd8, '1, '1, '1, '1, 32'd1));
    endtask

    // Fire on the count; then show the count is held while disabled and is kept
    // across a change of limit, so a lowered limit fires at once.
    task automatic test_count_trigger();
        configure(1'b1, 16'd3, 1'b0, '0);
        send_item(quote(48'd10, 32'd200, 32'd220, 32'd180, 32'd210, 32'd5));
        send_item(quote(48'd11, 32'd210, 32'd250, 32'd170, 32'd190, 32'd6));
        send_item(quote(48'd12, 32'd190, 32'd195, 32'd185, 32'd192, 32'd7));
        configure(1'b1, '1, 1'b0, '0);
        send_item(quote(48'd13, 32'd1, 32'd2, 32'd0, 32'd1, 32'd1));
        send_item(quote(48'd14, 32'd3, 32'd4, 32'd2, 32'd3, 32'd1));
        configure(1'b0, 16'd1, 1'b0, '0);
        send_item(quote(48'd15, 32'd5, 32'd6, 32'd4, 32'd5, 32'd1));
        configure(1'b1, 16'd2, 1'b0, '0);
        send_item(quote(48'd16, 32'd7, 32'd9, 32'd6, 32'd8, 32'd1));
    endtask

    // Period trigger: the first item sets the reference, an older item never fires
    // even with a zero period, and the widest period fires only on its full span.
    task automatic test_period_trigger();
        configure(1'b0, '0, 1'b1, 40'd10);
        send_item(quote(48'd1000, 32'd300, 32'd320, 32'd280, 32'd310, 32'd2));
        send_item(quote(48'd1005, 32'd310, 32'd330, 32'd300, 32'd305, 32'd2));
        send_item(quote(48'd990, 32'd305, 32'd340, 32'd260, 32'd300, 32'd2));
        send_item(quote(48'd1010, 32'd300, 32'd301, 32'd299, 32'd300, 32'd2));
        configure(1'b0, '0, 1'b1, '0);
        send_item(quote(48'd500, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9));
        send_item(quote(48'd1010, 32'd8, 32'd10, 32'd7, 32'd8, 32'd9));
        configure(1'b0, '0, 1'b1, '1);
        send_item(quote(48'd1010 + 48'hFF_FFFF_FFFE, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1));
        send_item(quote(48'd1010 + 48'hFF_FFFF_FFFF, 32'd2, 32'd2, 32'd2, 32'd2, 32'd1));
    endtask

    // Pile full-scale volume into one bar until the sum clips, then release it.
    task automatic test_volume_saturation();
        int unsigned i;
        configure(1'b0, '0, 1'b0, '0);
        for (i = 0; i < SatItems; i++) begin
            send_item(quote(48'd2000 + i, $urandom, $urandom, $urandom, $urandom, '1));
        end
        configure(1'b1, '0, 1'b0, '0);
        send_item(quote(48'd3000, $urandom, $urandom, $urandom, $urandom, '1));
    endtask

    // Random phases: a fresh setting per phase, market-like items, and a pause
    // halfway through each phase until every bar is out.
    task automatic test_random_bars();
        int unsigned        p;
        int unsigned        n;
        int unsigned        mode;
        int unsigned        roll;
        int unsigned        step_max;
        logic [CountW-1:0]  limit;
        logic [PeriodW-1:0] period;
        for (p = 0; p < RandPhases; p++) begin
            step_max = $urandom_range(1, 400);
            mode     = $urandom_range(0, 2);
            roll     = $urandom_range(0, 9);
            if (roll == 0) begin
                limit = '0;
            end else if (roll == 1) begin
                limit = '1;
            end else if (roll == 2) begin
                limit = CountW'($urandom);
            end else begin
                limit = CountW'($urandom_range(1, 12));
            end
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                period = '0;
            end else if (roll == 1) begin
                period = '1;
            end else begin
                period = PeriodW'($urandom_range(0, step_max * 12));
            end
            // Mode 0 counts only, mode 1 times only, mode 2 uses both.
            configure(mode != 1, limit, mode != 0, period);
            for (n = 0; n < PhaseItems; n++) begin
                if (n == PhaseItems / 2) begin
                    drain_results(0);
                end
                send_item(make_bar_item(step_max));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        item_ch.valid        = 1'b0;
        item_ch.timestamp    = '0;
        item_ch.open_price   = '0;
        item_ch.high_price   = '0;
        item_ch.low_price    = '0;
        item_ch.close_price  = '0;
        item_ch.trade_volume = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_accumulate_without_trigger();
        test_count_trigger();
        test_period_trigger();
        test_volume_saturation();
        test_random_bars();

        drain_results(EndSlack);
        if (mismatches == 0 && expected_bars.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
